// ===== src/lcee_pkg.sv =====
// shared types, codes and constants of the linear chain equation evaluator
package lcee_pkg;

   localparam int MAX_NODES_DEF = 8;
   localparam int FRAC_BITS_DEF = 16;
   localparam int DATA_W        = 32;

   localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

   typedef enum logic [1:0] {
      OP_ADD  = 2'd0,
      OP_SUB  = 2'd1,
      OP_MUL  = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      VAR_X    = 2'd0,
      VAR_Y    = 2'd1,
      VAR_Z    = 2'd2,
      VAR_NONE = 2'd3
   } sel_type;

   typedef enum logic {
      CSR_ROOT_VALUE = 1'b0,
      CSR_NODE_COUNT = 1'b1
   } csr_type;

   typedef enum logic {
      MODE_WRITE = 1'b0,
      MODE_EVAL  = 1'b1
   } mode_type;

   typedef struct packed {
      op_type                   op;
      sel_type                  sel;
      logic signed [DATA_W-1:0] coeff;
   } node_type;

   // constant that stands for the variable code none, clamped to 32 bits
   function automatic logic signed [DATA_W-1:0] none_value(input int frac);
      longint v;
      begin
         v = -64'sd10000 * (64'sd1 <<< frac);
         if (v < -64'sd2147483648) begin
            none_value = S32_MIN;
         end else begin
            none_value = v[DATA_W-1:0];
         end
      end
   endfunction

endpackage

// ===== src/lcee_node_mem.sv =====
// node table: one write port, one registered read port
module lcee_node_mem import lcee_pkg::*; #(
   parameter int DEPTH = MAX_NODES_DEF,
   parameter int AW    = 3
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  node_type      wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output node_type      rd_data
);

   node_type node_mem [DEPTH];
   node_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= node_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/linear_chain_equation_evaluator.sv =====
// top level: node table, sequencer and shared multiply / saturate datapath
//
// A transaction with req_tuser low writes one node (operation, variable,
// coefficient) into the table and gives no result. A transaction with
// req_tuser high evaluates one sample: the accumulator starts at root_value
// and the first node_count nodes (at most MAX_NODES) are folded in order, in
// Q(32-FRAC_BITS).FRAC_BITS with rounding and saturation; the result and a
// sticky overflow flag leave through a registered output, and the next
// transaction is taken while that result waits. Per node: registered table
// read; op none resets the accumulator to root_value, else coeff*var from the
// shared 32x32 multiplier is rounded, then added or subtracted, or multiplied
// by the accumulator and rounded again; req_tready is low from the cycle after
// the evaluate transaction until the result is loaded.
module linear_chain_equation_evaluator import lcee_pkg::*; #(
   parameter int MAX_NODES = MAX_NODES_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // node_index[2:0], node_op[4:3], node_var[6:5], node_coeff[38:7],
   // sample_x[70:39], sample_y[102:71], sample_z[134:103], zero[135]
   input  logic [135:0] req_tdata,
   // mode[0]
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // equation_value[31:0]
   output logic [31:0]  rsp_tdata,
   // overflow[0]
   output logic         rsp_tuser,
   input  logic         csr_wen,
   input  logic         csr_addr,
   input  logic [31:0]  csr_wdata
);

   localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CW = $clog2(MAX_NODES + 1);
   localparam logic signed [DATA_W-1:0] NONE_VAL = none_value(FRAC_BITS);
   localparam logic signed [63:0] HALF_LSB = 64'sd1 <<< (FRAC_BITS - 1);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_READ = 7'b0000010,
      S_EXEC = 7'b0000100,
      S_TSAT = 7'b0001000,
      S_ACC  = 7'b0010000,
      S_MUL2 = 7'b0100000,
      S_ASAT = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      done_ff, done_in;

   // request fields
   logic [2:0]               f_index;
   node_type                 f_node;
   logic signed [DATA_W-1:0] f_x, f_y, f_z;
   logic [31:0]              idx_wide;
   logic                     req_fire;

   // configuration
   logic signed [DATA_W-1:0] root_ff, root_in;
   logic [3:0]               count_ff, count_in;

   // datapath
   logic signed [DATA_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [DATA_W-1:0] acc_ff, acc_in, t_ff, t_in;
   logic                     ovf_ff, ovf_in;
   logic [CW-1:0]            cnt_ff, cnt_in, n_ff, n_in, cnt_next, n_req;
   logic signed [63:0]       prod_ff, prod_in;
   logic signed [DATA_W-1:0] mul_a, mul_b, var_val;
   logic signed [63:0]       rnd_sum, rnd_shf;
   logic                     rnd_ovf;
   logic signed [DATA_W-1:0] rnd_val;
   logic signed [DATA_W:0]   acc_sum;
   logic                     acc_ovf;
   logic signed [DATA_W-1:0] acc_val;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [31:0]              rsp_data_ff, rsp_data_in;
   logic                     rsp_ovf_ff, rsp_ovf_in;
   logic                     rsp_load;

   // table port
   logic     mem_wr_en, mem_rd_en;
   node_type mem_rd_data;

   assign f_index      = req_tdata[2:0];
   assign f_node.op    = op_type'(req_tdata[4:3]);
   assign f_node.sel   = sel_type'(req_tdata[6:5]);
   assign f_node.coeff = req_tdata[38:7];
   assign f_x          = req_tdata[70:39];
   assign f_y          = req_tdata[102:71];
   assign f_z          = req_tdata[134:103];
   assign idx_wide     = 32'(f_index);

   assign req_tready = (state_ff == S_IDLE) && !done_ff;
   assign req_fire   = req_tvalid && req_tready;

   assign mem_wr_en = req_fire && (mode_type'(req_tuser) == MODE_WRITE) &&
                      (idx_wide < 32'(MAX_NODES));
   assign mem_rd_en = (state_ff == S_READ) && !done_ff;

   lcee_node_mem #(
      .DEPTH (MAX_NODES),
      .AW    (AW)
   ) u_node_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (idx_wide[AW-1:0]),
      .wr_data (f_node),
      .rd_en   (mem_rd_en),
      .rd_addr (cnt_ff[AW-1:0]),
      .rd_data (mem_rd_data)
   );

   // node_count above the table depth applies the whole table
   assign n_req = (32'(count_ff) > 32'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(count_ff);
   assign cnt_next = cnt_ff + CW'(1);

   always_comb begin
      case (mem_rd_data.sel)
         VAR_X:   var_val = x_ff;
         VAR_Y:   var_val = y_ff;
         VAR_Z:   var_val = z_ff;
         default: var_val = NONE_VAL;
      endcase
   end

   // shared multiplier: coeff * var, then acc * t
   assign mul_a   = (state_ff == S_MUL2) ? acc_ff : mem_rd_data.coeff;
   assign mul_b   = (state_ff == S_MUL2) ? t_ff : var_val;
   assign prod_in = mul_a * mul_b;

   // round to nearest, ties up, then saturate
   assign rnd_sum = prod_ff + HALF_LSB;
   assign rnd_shf = rnd_sum >>> FRAC_BITS;
   assign rnd_ovf = !((&rnd_shf[63:31]) || !(|rnd_shf[63:31]));
   assign rnd_val = rnd_ovf ? (rnd_shf[63] ? S32_MIN : S32_MAX) : rnd_shf[31:0];

   assign acc_sum = (mem_rd_data.op == OP_SUB) ?
                    ({acc_ff[DATA_W-1], acc_ff} - {t_ff[DATA_W-1], t_ff}) :
                    ({acc_ff[DATA_W-1], acc_ff} + {t_ff[DATA_W-1], t_ff});
   assign acc_ovf = acc_sum[DATA_W] != acc_sum[DATA_W-1];
   assign acc_val = acc_ovf ? (acc_sum[DATA_W] ? S32_MIN : S32_MAX) : acc_sum[DATA_W-1:0];

   assign rsp_load = done_ff && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      done_in  = done_ff;
      root_in  = root_ff;
      count_in = count_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      acc_in   = acc_ff;
      t_in     = t_ff;
      ovf_in   = ovf_ff;
      cnt_in   = cnt_ff;
      n_in     = n_ff;

      if (csr_wen) begin
         unique case (csr_type'(csr_addr))
            CSR_ROOT_VALUE: root_in  = csr_wdata;
            CSR_NODE_COUNT: count_in = csr_wdata[3:0];
            default:        ;
         endcase
      end

      if (done_ff) begin
         if (rsp_load) begin
            done_in  = 1'b0;
            state_in = S_IDLE;
         end
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire && (mode_type'(req_tuser) == MODE_EVAL)) begin
                  x_in   = f_x;
                  y_in   = f_y;
                  z_in   = f_z;
                  acc_in = root_ff;
                  ovf_in = 1'b0;
                  cnt_in = '0;
                  n_in   = n_req;
                  if (n_req == '0) begin
                     done_in = 1'b1;
                  end else begin
                     state_in = S_READ;
                  end
               end
            end
            S_READ: state_in = S_EXEC;
            S_EXEC: begin
               if (mem_rd_data.op == OP_NONE) begin
                  acc_in = root_ff;
                  cnt_in = cnt_next;
                  if (cnt_next == n_ff) begin
                     done_in  = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_READ;
                  end
               end else begin
                  state_in = S_TSAT;
               end
            end
            S_TSAT: begin
               t_in   = rnd_val;
               ovf_in = ovf_ff | rnd_ovf;
               state_in = (mem_rd_data.op == OP_MUL) ? S_MUL2 : S_ACC;
            end
            S_MUL2: state_in = S_ASAT;
            S_ACC, S_ASAT: begin
               if (state_ff == S_ACC) begin
                  acc_in = acc_val;
                  ovf_in = ovf_ff | acc_ovf;
               end else begin
                  acc_in = rnd_val;
                  ovf_in = ovf_ff | rnd_ovf;
               end
               cnt_in = cnt_next;
               if (cnt_next == n_ff) begin
                  done_in  = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_READ;
               end
            end
            default: state_in = S_IDLE;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
      rsp_data_in  = rsp_load ? acc_ff : rsp_data_ff;
      rsp_ovf_in   = rsp_load ? ovf_ff : rsp_ovf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         done_ff      <= 1'b0;
         root_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         n_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         done_ff      <= done_in;
         root_ff      <= root_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         n_ff         <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      acc_ff      <= acc_in;
      t_ff        <= t_in;
      ovf_ff      <= ovf_in;
      rsp_data_ff <= rsp_data_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      if ((state_ff == S_EXEC) || (state_ff == S_MUL2)) begin
         prod_ff <= prod_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ovf_ff;

endmodule

// ===== src/lcee_checker.sv =====
// port-level checks of the evaluator, bound to the top level
module lcee_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [31:0]  rsp_tdata,
   input logic         rsp_tuser
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // a node write finishes in its own cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser |=> req_tready)
      else $error("node write stalled the input");

   // an evaluation closes the input in the cycle after the evaluate transaction
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> !req_tready)
      else $error("input open right after an evaluate transaction");

   // a new result only appears at the end of an evaluation
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result without an evaluation");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind linear_chain_equation_evaluator lcee_checker u_lcee_checker (.*);
